// ===== src/vad_pkg.sv =====
// vad_pkg: widths, payload and pipeline types, and the arctangent step table
// for the vector angle block. depends on nothing.
package vad_pkg;

	localparam int COORD_BITS      = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int OUT_BITS        = 18;
	localparam int DIFF_BITS       = COORD_BITS + 1;

	// rotation datapath: magnitude, gain and sign headroom, then guard bits
	localparam int GUARD_BITS = 64;
	localparam int XY_W       = COORD_BITS + 3 + GUARD_BITS;

	// angle accumulator in degrees
	localparam int Z_FRAC     = 62;
	localparam int Z_INT_BITS = 8;
	localparam int Z_W        = Z_FRAC + Z_INT_BITS;

	localparam int NSTAGE = 60;
	localparam int IDX_W  = $clog2(NSTAGE);

	// table generation only
	localparam int SER_FRAC = 124;
	localparam int SER_W    = 140;
	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;
	localparam logic [Z_W-1:0] DEG45 = Z_W'(45) << Z_FRAC;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0]   angle_t;

	localparam angle_t ANGLE_P90 = angle_t'(90 << ANGLE_FRAC_BITS);
	localparam angle_t ANGLE_M90 = angle_t'(-(90 << ANGLE_FRAC_BITS));
	localparam angle_t ANGLE_180 = angle_t'(180 << ANGLE_FRAC_BITS);

	typedef struct packed {
		logic dx_neg;
		logic dy_neg;
		logic dx_zero;
	} side_t;

	typedef struct packed {
		logic                   valid;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		side_t                  side;
	} cell_t;

	typedef logic [Z_W-1:0] atan_tbl_t [NSTAGE];

	// restoring long division, table generation only
	function automatic logic [SER_W-1:0] long_div(input logic [SER_W-1:0] num,
		input logic [SER_W-1:0] den);
		logic [SER_W-1:0] quo;
		logic [SER_W:0]   rem;
		quo = '0;
		rem = '0;
		for (int b = SER_W - 1; b >= 0; b--) begin
			rem = {rem[SER_W-1:0], num[b]};
			quo = quo << 1;
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in degrees, series evaluated at elaboration
	function automatic logic [Z_W-1:0] atan_deg(input int unsigned i);
		logic [SER_W-1:0] acc;
		logic [SER_W-1:0] term;
		logic [SER_W-1:0] deg;
		int unsigned      odd;
		acc = '0;
		for (int unsigned k = 0; k < 64; k++) begin
			odd = 2 * k + 1;
			if (i * odd <= SER_FRAC) begin
				term = long_div(SER_W'(1) << (SER_FRAC - i * odd), SER_W'(odd));
				if (k[0]) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		deg = long_div(acc * SER_W'(180), SER_W'(PI_Q62));
		if (i == 0) begin
			return DEG45;
		end
		return deg[Z_W-1:0];
	endfunction

	function automatic atan_tbl_t atan_table();
		atan_tbl_t t;
		for (int i = 0; i < NSTAGE; i++) begin
			t[i] = atan_deg(unsigned'(i));
		end
		return t;
	endfunction

	localparam atan_tbl_t ATAN_TABLE = atan_table();

endpackage

// ===== src/vad_if.sv =====
// vad_if: valid/ready channel interfaces for point pairs and angles
// depends on vad_pkg
interface vad_in_if;
	import vad_pkg::*;

	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

interface vad_out_if;
	import vad_pkg::*;

	logic   valid;
	logic   ready;
	angle_t angle_deg_q8;

	modport source (output valid, output angle_deg_q8, input ready);
	modport sink (input valid, input angle_deg_q8, output ready);
endinterface

// ===== src/vector_angle_degrees.sv =====
// vector_angle_degrees: direction of the vector between two points, in
// degrees times 256. depends on vad_pkg, vad_if, vad_prep, vad_cell, vad_post
//
//   channel  dir  payload                              transaction
//   points   in   start_x, start_y, end_x, end_y       one point pair
//   result   out  angle_deg_q8                         one angle
//
// one transaction per cycle in each direction when not held; from points to result:
// one difference stage, 60 rotation cells, one output register
// the whole pipeline advances together; it holds while result is valid and
// not taken, and points.ready follows that hold
// reset clears the valid bits of every stage and of the output register
module vector_angle_degrees (
	input logic       clk,
	input logic       arst_n,
	vad_in_if.sink    points,
	vad_out_if.source result
);
	import vad_pkg::*;

	logic   en;
	cell_t  chain [NSTAGE+1];
	angle_t angle;
	logic   out_valid_q;
	angle_t angle_q;

	assign en = !out_valid_q || result.ready;
	assign points.ready = en;

	vad_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (points.valid),
		.start_x (points.start_x),
		.start_y (points.start_y),
		.end_x   (points.end_x),
		.end_y   (points.end_y),
		.q       (chain[0])
	);

	for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
		vad_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.stage_idx (IDX_W'(g)),
			.d         (chain[g]),
			.q         (chain[g+1])
		);
	end

	vad_post u_post (
		.d     (chain[NSTAGE]),
		.angle (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[NSTAGE].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= angle;
		end
	end

	assign result.valid = out_valid_q;
	assign result.angle_deg_q8 = angle_q;

endmodule

// ===== src/vad_prep.sv =====
// vad_prep: forms dx, dy and their magnitudes, loads the first rotation cell
// depends on vad_pkg
module vad_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid,
	input  vad_pkg::coord_t start_x,
	input  vad_pkg::coord_t start_y,
	input  vad_pkg::coord_t end_x,
	input  vad_pkg::coord_t end_y,
	output vad_pkg::cell_t  q
);
	import vad_pkg::*;

	logic signed [DIFF_BITS-1:0] dx;
	logic signed [DIFF_BITS-1:0] dy;
	logic [COORD_BITS-1:0]       abs_dx;
	logic [COORD_BITS-1:0]       abs_dy;

	logic                   valid_s1;
	logic signed [XY_W-1:0] x_s1;
	logic signed [XY_W-1:0] y_s1;
	side_t                  side_s1;

	assign dx = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
	assign dy = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
	assign abs_dx = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
	assign abs_dy = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= $signed({{(XY_W - COORD_BITS - GUARD_BITS){1'b0}}, abs_dx,
				{GUARD_BITS{1'b0}}});
			y_s1 <= $signed({{(XY_W - COORD_BITS - GUARD_BITS){1'b0}}, abs_dy,
				{GUARD_BITS{1'b0}}});
			side_s1.dx_neg  <= dx[DIFF_BITS-1];
			side_s1.dy_neg  <= dy[DIFF_BITS-1];
			side_s1.dx_zero <= (dx == '0);
		end
	end

	assign q = '{valid: valid_s1, x: x_s1, y: y_s1, z: '0, side: side_s1};

endmodule

// ===== src/vad_cell.sv =====
// vad_cell: one vectoring rotation step, drives y toward zero and
// accumulates the angle in degrees. depends on vad_pkg
module vad_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [vad_pkg::IDX_W-1:0] stage_idx,
	input  vad_pkg::cell_t            d,
	output vad_pkg::cell_t            q
);
	import vad_pkg::*;

	logic signed [XY_W-1:0] x_sh;
	logic signed [XY_W-1:0] y_sh;
	logic signed [XY_W-1:0] x_nxt;
	logic signed [XY_W-1:0] y_nxt;
	logic signed [Z_W-1:0]  step;
	logic signed [Z_W-1:0]  z_nxt;

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	side_t                  side_q;

	assign x_sh = $signed(d.x) >>> stage_idx;
	assign y_sh = $signed(d.y) >>> stage_idx;
	assign step = $signed(ATAN_TABLE[stage_idx]);

	always_comb begin
		if (d.y[XY_W-1]) begin
			x_nxt = $signed(d.x) - y_sh;
			y_nxt = $signed(d.y) + x_sh;
			z_nxt = $signed(d.z) - step;
		end else begin
			x_nxt = $signed(d.x) + y_sh;
			y_nxt = $signed(d.y) - x_sh;
			z_nxt = $signed(d.z) + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			z_q    <= z_nxt;
			side_q <= d.side;
		end
	end

	assign q = '{valid: valid_q, x: x_q, y: y_q, z: z_q, side: side_q};

endmodule

// ===== src/vad_post.sv =====
// vad_post: rounds the accumulated angle, applies quadrant and the
// vertical cases. depends on vad_pkg
module vad_post (
	input  vad_pkg::cell_t  d,
	output vad_pkg::angle_t angle
);
	import vad_pkg::*;

	localparam int SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [Z_W-1:0] HALF = Z_W'(1) << (SHIFT - 1);

	logic signed [Z_W-1:0] rounded;
	angle_t                mag;
	angle_t                signed_mag;

	assign rounded = ($signed(d.z) + HALF) >>> SHIFT;
	assign mag = angle_t'(rounded);
	assign signed_mag = (d.side.dx_neg != d.side.dy_neg) ? -mag : mag;

	always_comb begin
		priority if (d.side.dx_zero) begin
			angle = d.side.dy_neg ? ANGLE_M90 : ANGLE_P90;
		end else if (d.side.dx_neg) begin
			angle = signed_mag + ANGLE_180;
		end else begin
			angle = signed_mag;
		end
	end

endmodule
